/* sv/tsc_pkg.sv */
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants for the thresholded spot centroid
// Widths of the accumulators, the per-frame stats record and back-end states.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS     = 8;
  localparam int PIX_BITS      = 8;
  localparam int CENT_BITS     = COORD_BITS + FRAC_BITS;
  localparam int WEIGHT_BITS   = 2 * COORD_BITS + PIX_BITS;
  localparam int SUM_BITS      = 3 * COORD_BITS + PIX_BITS;
  localparam int COUNT_BITS    = 2 * COORD_BITS + 1;
  localparam int PROD_BITS     = PIX_BITS + COORD_BITS;
  localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);

  localparam logic [PIX_BITS-1:0] DEFAULT_THRESHOLD = PIX_BITS'(50);

  // One finished frame, as handed from the front end to the back end.
  // Box fields are already forced to zero when no pixel passed.
  typedef struct packed {
    logic [SUM_BITS-1:0]    x_sum;
    logic [SUM_BITS-1:0]    y_sum;
    logic [WEIGHT_BITS-1:0] weight;
    logic [COUNT_BITS-1:0]  count;
    logic [COORD_BITS-1:0]  left;
    logic [COORD_BITS-1:0]  top;
    logic [COORD_BITS-1:0]  right;
    logic [COORD_BITS-1:0]  bottom;
  } frame_stats_t;

  // Queue handshake between front end and back end.
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIV,
    BACK_HOLD
  } back_state_t;

endpackage

/* sv/tsc_front.sv */
// ----------------------------------------------------------------------------
// tsc_front: pixel intake and per-frame accumulation
// Thresholds each pixel, updates sums, count and box, and pushes the frame
// record on the last pixel of the frame.
// ----------------------------------------------------------------------------
module tsc_front import tsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [PIX_BITS-1:0]   cfg_write_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_BITS-1:0]   pixel_value,
  input  logic [COORD_BITS-1:0] column,
  input  logic [COORD_BITS-1:0] row,
  input  logic                  frame_last,
  input  logic                  queue_full,
  output logic                  push,
  output frame_stats_t          push_data
);

  logic [PIX_BITS-1:0]    threshold;
  logic [WEIGHT_BITS-1:0] weight_total,   weight_total_next;
  logic [SUM_BITS-1:0]    weighted_x_sum, weighted_x_sum_next;
  logic [SUM_BITS-1:0]    weighted_y_sum, weighted_y_sum_next;
  logic [COUNT_BITS-1:0]  pass_counter,   pass_counter_next;
  logic [COORD_BITS-1:0]  min_column,     min_column_next;
  logic [COORD_BITS-1:0]  min_row,        min_row_next;
  logic [COORD_BITS-1:0]  max_column,     max_column_next;
  logic [COORD_BITS-1:0]  max_row,        max_row_next;
  logic [PROD_BITS-1:0]   prod_x, prod_y;
  logic                   accept, passes, found;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign passes   = pixel_value > threshold;
  assign prod_x   = PROD_BITS'(pixel_value) * PROD_BITS'(column);
  assign prod_y   = PROD_BITS'(pixel_value) * PROD_BITS'(row);

  // Accumulator values including the current pixel.
  always_comb begin
    weight_total_next   = weight_total;
    weighted_x_sum_next = weighted_x_sum;
    weighted_y_sum_next = weighted_y_sum;
    pass_counter_next   = pass_counter;
    min_column_next     = min_column;
    min_row_next        = min_row;
    max_column_next     = max_column;
    max_row_next        = max_row;
    if (passes) begin
      weight_total_next   = weight_total + WEIGHT_BITS'(pixel_value);
      weighted_x_sum_next = weighted_x_sum + SUM_BITS'(prod_x);
      weighted_y_sum_next = weighted_y_sum + SUM_BITS'(prod_y);
      pass_counter_next   = pass_counter + COUNT_BITS'(1);
      if (column < min_column) min_column_next = column;
      if (row < min_row)       min_row_next    = row;
      if (column > max_column) max_column_next = column;
      if (row > max_row)       max_row_next    = row;
    end
  end

  assign found = pass_counter_next != '0;
  assign push  = accept && frame_last;

  always_comb begin
    push_data.x_sum  = weighted_x_sum_next;
    push_data.y_sum  = weighted_y_sum_next;
    push_data.weight = weight_total_next;
    push_data.count  = pass_counter_next;
    push_data.left   = found ? min_column_next : '0;
    push_data.top    = found ? min_row_next    : '0;
    push_data.right  = found ? max_column_next : '0;
    push_data.bottom = found ? max_row_next    : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= DEFAULT_THRESHOLD;
    end else if (cfg_write_en) begin
      threshold <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      weight_total   <= '0;
      weighted_x_sum <= '0;
      weighted_y_sum <= '0;
      pass_counter   <= '0;
      min_column     <= '1;
      min_row        <= '1;
      max_column     <= '0;
      max_row        <= '0;
    end else if (accept) begin
      weight_total   <= weight_total_next;
      weighted_x_sum <= weighted_x_sum_next;
      weighted_y_sum <= weighted_y_sum_next;
      pass_counter   <= pass_counter_next;
      min_column     <= min_column_next;
      min_row        <= min_row_next;
      max_column     <= max_column_next;
      max_row        <= max_row_next;
    end
  end

endmodule

/* sv/tsc_queue.sv */
// ----------------------------------------------------------------------------
// tsc_queue: two-entry queue of frame records
// Decouples the pixel intake from the division sequencer.
// ----------------------------------------------------------------------------
module tsc_queue import tsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  queue_ctrl_t  ctrl,
  input  frame_stats_t wr_data,
  output queue_stat_t  stat,
  output frame_stats_t rd_data
);

  frame_stats_t entries [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   fill;
  logic         do_push, do_pop;

  assign stat.full  = fill == 2'd2;
  assign stat.valid = fill != 2'd0;
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && stat.valid;
  assign rd_data    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* sv/tsc_divider.sv */
// ----------------------------------------------------------------------------
// tsc_divider: restoring divider, one quotient bit per cycle
// Keeps only the low CENT_BITS of the quotient.
// ----------------------------------------------------------------------------
module tsc_divider import tsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [WEIGHT_BITS-1:0]   divisor,
  output logic [CENT_BITS-1:0]     quotient,
  output logic                     done
);

  logic [WEIGHT_BITS-1:0]   rem;
  logic [WEIGHT_BITS-1:0]   dvs;
  logic [DIVIDEND_BITS-1:0] dvd;
  logic [DIV_CNT_BITS-1:0]  cnt;
  logic [WEIGHT_BITS:0]     trial, diff;
  logic                     qbit;

  assign trial = {rem, dvd[DIVIDEND_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = !diff[WEIGHT_BITS];

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (cnt != '0) begin
      dvd      <= {dvd[DIVIDEND_BITS-2:0], 1'b0};
      rem      <= qbit ? diff[WEIGHT_BITS-1:0] : trial[WEIGHT_BITS-1:0];
      quotient <= {quotient[CENT_BITS-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= cnt == DIV_CNT_BITS'(1);
      if (start) begin
        cnt <= DIV_CNT_BITS'(DIVIDEND_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - DIV_CNT_BITS'(1);
      end
    end
  end

endmodule

/* sv/tsc_back.sv */
// ----------------------------------------------------------------------------
// tsc_back: division sequencer and result register
// Pops a frame record, runs both centroid divisions, and presents the result.
// ----------------------------------------------------------------------------
module tsc_back import tsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  queue_stat_t           q_stat,
  input  frame_stats_t          q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CENT_BITS-1:0]  centroid_x_q8,
  output logic [CENT_BITS-1:0]  centroid_y_q8,
  output logic [COORD_BITS-1:0] box_left,
  output logic [COORD_BITS-1:0] box_top,
  output logic [COORD_BITS-1:0] box_right,
  output logic [COORD_BITS-1:0] box_bottom,
  output logic [COUNT_BITS-1:0] passing_count,
  output logic                  spot_found
);

  back_state_t           state, state_next;
  frame_stats_t          job;
  logic                  div_start, load_out, x_done, y_done, has_centroid;
  logic [CENT_BITS-1:0]  quo_x, quo_y;

  tsc_divider u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({q_data.x_sum, {FRAC_BITS{1'b0}}}),
    .divisor  (q_data.weight),
    .quotient (quo_x),
    .done     (x_done)
  );

  tsc_divider u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({q_data.y_sum, {FRAC_BITS{1'b0}}}),
    .divisor  (q_data.weight),
    .quotient (quo_y),
    .done     (y_done)
  );

  always_comb begin
    state_next = state;
    case (state)
      BACK_IDLE: if (q_stat.valid) state_next = BACK_DIV;
      BACK_DIV:  if (x_done && y_done) state_next = BACK_HOLD;
      BACK_HOLD: if (!out_valid || !out_stall) state_next = BACK_IDLE;
      default:   state_next = BACK_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      BACK_IDLE: div_start = q_stat.valid;
      BACK_HOLD: load_out  = !out_valid || !out_stall;
      default: begin
        div_start = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  assign pop          = div_start;
  assign has_centroid = (job.count != '0) && (job.weight != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BACK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      job <= q_data;
    end
    if (load_out) begin
      centroid_x_q8 <= has_centroid ? quo_x : '0;
      centroid_y_q8 <= has_centroid ? quo_y : '0;
      box_left      <= job.left;
      box_top       <= job.top;
      box_right     <= job.right;
      box_bottom    <= job.bottom;
      passing_count <= job.count;
      spot_found    <= job.count != '0;
    end
  end

endmodule

/* sv/thresholded_spot_centroid_core.sv */
// ----------------------------------------------------------------------------
// thresholded_spot_centroid_core: intensity-weighted spot centroid per frame
// Accumulates thresholded pixels of a raster frame and reports centroid,
// bounding box and pass count once per frame.
// ----------------------------------------------------------------------------
// Pixels enter at one per clock while in_stall is low: the front end
// thresholds each pixel against the threshold register (strictly greater
// passes, reset value 50) and folds it into the weight, weighted column/row
// sums, pass count and bounding box in the same cycle. The pixel flagged
// frame_last is counted first, then its frame record goes into a two-entry
// queue and the accumulators clear, so the next frame's first pixel can
// follow immediately. The back end pops a record and runs two bit-serial
// restoring dividers side by side, one quotient bit per clock over the
// 52-bit dividend (sum with 8 fraction bits appended); it starts on the
// next record only once the current result is loaded into the output
// register. Intake stalls only when two finished frames already wait in
// the queue. Centroids are truncated, 8 fraction bits, masked to 20 bits;
// with no passing pixel spot_found, box and centroid read 0. The result
// holds in an output register until taken, while the back end may start
// on the next frame.
// ----------------------------------------------------------------------------
module thresholded_spot_centroid_core import tsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // threshold register write
  input  logic                  cfg_write_en,
  input  logic [PIX_BITS-1:0]   cfg_write_data,
  // pixel requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_BITS-1:0]   pixel_value,
  input  logic [COORD_BITS-1:0] column,
  input  logic [COORD_BITS-1:0] row,
  input  logic                  frame_last,
  // frame result requests
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CENT_BITS-1:0]  centroid_x_q8,
  output logic [CENT_BITS-1:0]  centroid_y_q8,
  output logic [COORD_BITS-1:0] box_left,
  output logic [COORD_BITS-1:0] box_top,
  output logic [COORD_BITS-1:0] box_right,
  output logic [COORD_BITS-1:0] box_bottom,
  output logic [COUNT_BITS-1:0] passing_count,
  output logic                  spot_found
);

  queue_ctrl_t  q_ctrl;
  queue_stat_t  q_stat;
  frame_stats_t push_data, head_data;

  // Front end: threshold and accumulate; push on frame_last.
  tsc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel_value    (pixel_value),
    .column         (column),
    .row            (row),
    .frame_last     (frame_last),
    .queue_full     (q_stat.full),
    .push           (q_ctrl.push),
    .push_data      (push_data)
  );

  // Hold finished frames until the dividers are free.
  tsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (q_ctrl),
    .wr_data (push_data),
    .stat    (q_stat),
    .rd_data (head_data)
  );

  // Back end: divide and present the result.
  tsc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .q_data        (head_data),
    .pop           (q_ctrl.pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .centroid_x_q8 (centroid_x_q8),
    .centroid_y_q8 (centroid_y_q8),
    .box_left      (box_left),
    .box_top       (box_top),
    .box_right     (box_right),
    .box_bottom    (box_bottom),
    .passing_count (passing_count),
    .spot_found    (spot_found)
  );

endmodule
